### rtl/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared constants for the longest-increasing-subsequence tail search block.
// ----------------------------------------------------------------------------
package lis_pkg;

	// width of the sample port
	localparam int unsigned IN_W  = 32;
	// width of the reported length
	localparam int unsigned LEN_W = 11;

endpackage

### rtl/lis_ram.sv
// ----------------------------------------------------------------------------
// lis_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lis_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/lis_length_tail_search.sv
// An appending sample needs no search; a replacing sample is written at once
// to a one-entry store and otherwise placed by binary search. The search pace is
// set by the tail RAM's single read port, which serves one binary-search probe a cycle.
// Throughput: one sample at a time; in_ready is low until the sample retires.
// Reset: asynchronous, clears tail count, overflow flag and the output slot;
// the tail RAM itself is not cleared (only entries below the count are read).
// ----------------------------------------------------------------------------
// lis_length_tail_search
// Longest strictly increasing subsequence length by patience sorting, with a
// sorted tail store in RAM searched by lower-bound binary search.
// ----------------------------------------------------------------------------
module lis_length_tail_search #(
	parameter int unsigned MAX_TAILS  = 1024,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [lis_pkg::IN_W-1:0]   sample_value,
	input  logic                       last_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lis_pkg::LEN_W-1:0]  lis_length,
	output logic                       overflow
);
	import lis_pkg::*;

	localparam int unsigned IW = $clog2(MAX_TAILS);
	localparam int unsigned CW = $clog2(MAX_TAILS + 1);
	localparam int unsigned DW = DATA_WIDTH;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SRCH,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic                 ovf_q;
	logic                 last_q;
	logic                 out_valid_q;
	logic [LEN_W-1:0]     len_q;
	logic                 out_ovf_q;

	logic signed [DW-1:0] key_q;
	logic signed [DW-1:0] tail_q;    // copy of the last valid tail
	logic [IW-1:0]        lo_q;
	logic [IW-1:0]        hi_q;

	logic                       accept;
	logic signed [IN_W+DW-1:0]  sx;
	logic signed [DW-1:0]       key_in;
	logic                       is_append;
	logic                       full;
	logic [CW-1:0]              cnt_m1;
	logic [IW-1:0]              init_mid;
	logic [IW:0]                sum;
	logic [IW-1:0]              mid;
	logic signed [DW-1:0]       rdata;
	logic                       le;
	logic [IW-1:0]              nlo;
	logic [IW-1:0]              nhi;
	logic [IW:0]                nsum;
	logic                       hit;
	logic                       out_free;
	logic [CW+LEN_W-1:0]        cnt_ext;

	logic                       ram_we;
	logic [IW-1:0]              ram_waddr;
	logic [DW-1:0]              ram_wdata;
	logic [IW-1:0]              ram_raddr;
	logic [DW-1:0]              ram_rdata;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign lis_length = len_q;
	assign overflow   = out_ovf_q;
	assign out_free   = !out_valid_q || out_ready;

	// low DATA_WIDTH bits, sign-extended when DATA_WIDTH exceeds the port
	assign sx        = {{DW{sample_value[IN_W-1]}}, sample_value};
	assign key_in    = sx[DW-1:0];
	assign full      = (count_q == CW'(MAX_TAILS));
	assign is_append = (count_q == '0) || (key_in > tail_q);
	assign cnt_m1    = count_q - CW'(1);
	assign init_mid  = cnt_m1[IW-1:0] >> 1;
	assign cnt_ext   = {{LEN_W{1'b0}}, count_q};

	// one probe per cycle: compare against the tail read last cycle
	assign sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid   = sum[IW:1];
	assign rdata = ram_rdata;
	assign le    = (key_q <= rdata);
	assign nlo   = le ? lo_q : (mid + IW'(1));
	assign nhi   = le ? mid : hi_q;
	assign nsum  = {1'b0, nlo} + {1'b0, nhi};
	assign hit   = (nlo == nhi);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = key_q;
		ram_raddr = nsum[IW:1];
		case (state_q)
			ST_IDLE: begin
				ram_wdata = key_in;
				ram_raddr = init_mid;
				if (accept) begin
					if (is_append) begin
						ram_we    = !full;
						ram_waddr = count_q[IW-1:0];
					end else if (count_q == CW'(1)) begin
						ram_we    = 1'b1;
					end
				end
			end
			ST_SRCH: begin
				ram_we    = hit;
				ram_waddr = nlo;
			end
			default: begin
			end
		endcase
	end

	lis_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_TAILS)
	) u_tail_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			len_q       <= '0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (out_ready && !(state_q == ST_DONE && last_q)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= last_item;
						if (is_append) begin
							if (!full) begin
								count_q <= count_q + CW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
							state_q <= ST_DONE;
						end else if (count_q == CW'(1)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SRCH;
						end
					end
				end
				ST_SRCH: begin
					if (hit) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						len_q       <= cnt_ext[LEN_W-1:0];
						out_ovf_q   <= ovf_q;
						count_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// search payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_q <= key_in;
					lo_q  <= '0;
					hi_q  <= cnt_m1[IW-1:0];
					if ((is_append && !full) || (!is_append && count_q == CW'(1))) begin
						tail_q <= key_in;
					end
				end
			end
			ST_SRCH: begin
				lo_q <= nlo;
				hi_q <= nhi;
				if (hit && nlo == cnt_m1[IW-1:0]) begin
					tail_q <= key_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/lis_checker.sv
// ----------------------------------------------------------------------------
// lis_sva
// Port-level checks for lis_length_tail_search, bound to the top level.
// ----------------------------------------------------------------------------
module lis_sva #(
	parameter int unsigned MAX_TAILS = 1024
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [lis_pkg::LEN_W-1:0] lis_length,
	input logic                      overflow
);
	import lis_pkg::*;

	localparam logic [LEN_W+31:0] MaxExt = (LEN_W + 32)'(MAX_TAILS);

	// a result waiting on the sink holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(lis_length) && $stable(overflow))
		else $error("result changed while stalled");

	// every accepted sample makes the block busy: in_ready falls after each transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");

	// a dropped append means the store was full
	a_ovf_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> lis_length == MaxExt[LEN_W-1:0])
		else $error("overflow reported with store not full");

	// a new result never appears while the block is taking input
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a finished transaction");

endmodule

bind lis_length_tail_search lis_sva #(.MAX_TAILS(MAX_TAILS)) u_lis_sva (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.lis_length (lis_length),
	.overflow   (overflow)
);

### sim/lis_checker.sv
// ----------------------------------------------------------------------------
// lis_checker
// Watches both channels of the tail search block, keeps its own sorted tail
// store to predict length and overflow for each sequence, and compares each
// result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module lis_checker #(
	parameter int unsigned MAX_TAILS  = 1024,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [lis_pkg::IN_W-1:0]  sample_value,
	input  logic                      last_item,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [lis_pkg::LEN_W-1:0] lis_length,
	input  logic                      overflow,
	output int                        fail_count,
	output int                        pending,
	output int                        samples_seen,
	output int                        results_seen,
	output int                        longest_seen,
	output int                        overflow_results
);
	import lis_pkg::*;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             ovf;
	} lis_result_t;

	logic signed [IN_W-1:0] tails [MAX_TAILS];
	int unsigned            tail_cnt = 0;
	bit                     ovf_seen = 1'b0;
	lis_result_t            lis_expected [$];
	lis_result_t            oldest;

	int n_fail    = 0;
	int n_pending = 0;
	int n_samples = 0;
	int n_results = 0;
	int n_longest = 0;
	int n_ovf     = 0;

	assign fail_count       = n_fail;
	assign pending          = n_pending;
	assign samples_seen     = n_samples;
	assign results_seen     = n_results;
	assign longest_seen     = n_longest;
	assign overflow_results = n_ovf;

	// low DATA_WIDTH bits, sign-extended
	function automatic logic signed [IN_W-1:0] widen(input logic [IN_W-1:0] raw);
		return $signed(raw << (IN_W - DATA_WIDTH)) >>> (IN_W - DATA_WIDTH);
	endfunction

	task automatic absorb_sample(input logic [IN_W-1:0] raw, input logic last);
		logic signed [IN_W-1:0] v;
		int unsigned            lo;
		int unsigned            hi;
		int unsigned            mid;
		lis_result_t            r;
		v = widen(raw);
		if (tail_cnt == 0 || v > tails[tail_cnt - 1]) begin
			if (tail_cnt < MAX_TAILS) begin
				tails[tail_cnt] = v;
				tail_cnt++;
			end else begin
				ovf_seen = 1'b1;
			end
		end else begin
			// lower bound: first tail not less than v
			lo = 0;
			hi = tail_cnt - 1;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (v <= tails[mid])
					hi = mid;
				else
					lo = mid + 1;
			end
			tails[lo] = v;
		end
		if (last) begin
			r.len = LEN_W'(tail_cnt);
			r.ovf = ovf_seen;
			lis_expected.push_back(r);
			if (int'(tail_cnt) > n_longest)
				n_longest = tail_cnt;
			if (ovf_seen)
				n_ovf++;
			tail_cnt = 0;
			ovf_seen = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				n_samples++;
				absorb_sample(sample_value, last_item);
			end
			if (out_valid && out_ready) begin
				n_results++;
				if (lis_expected.size() == 0) begin
					$error("unexpected result transaction: lis_length=%0d overflow=%0b",
						lis_length, overflow);
					n_fail++;
				end else begin
					oldest = lis_expected.pop_front();
					if (lis_length !== oldest.len) begin
						$error("lis_length mismatch: expected %0d, actual %0d",
							oldest.len, lis_length);
						n_fail++;
					end
					if (overflow !== oldest.ovf) begin
						$error("overflow mismatch: expected %0b, actual %0b",
							oldest.ovf, overflow);
						n_fail++;
					end
				end
			end
			n_pending = lis_expected.size();
		end
	end

endmodule

### sim/tb_lis_length_tail_search.sv
// ----------------------------------------------------------------------------
// tb_lis_length_tail_search
// Drives sample sequences into the tail search block: directed corner cases,
// a receiver hold-off, random sequences with random gaps and stalls, and two
// runs that fill the tail store, one of them past full.
// ----------------------------------------------------------------------------
module tb_lis_length_tail_search;
	import lis_pkg::*;

	localparam int unsigned MAX_TAILS    = 1024;
	localparam int unsigned DATA_WIDTH   = 32;
	localparam int          RUN_LIMIT    = 10_000_000;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          TAIL_WAIT    = 24;
	localparam int          RANDOM_ITEMS = 400;
	localparam longint      MIN_VALUE    = -64'sd2147483648;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             in_valid     = 1'b0;
	logic [IN_W-1:0]  sample_value = '0;
	logic             last_item    = 1'b0;
	logic             out_ready    = 1'b0;
	logic             in_ready;
	logic             out_valid;
	logic [LEN_W-1:0] lis_length;
	logic             overflow;

	int fail_count;
	int pending;
	int samples_seen;
	int results_seen;
	int longest_seen;
	int overflow_results;

	bit quiet     = 1'b0;
	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;
	int sent_random;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	lis_length_tail_search #(
		.MAX_TAILS  (MAX_TAILS),
		.DATA_WIDTH (DATA_WIDTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_value (sample_value),
		.last_item    (last_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.lis_length   (lis_length),
		.overflow     (overflow)
	);

	lis_checker #(
		.MAX_TAILS  (MAX_TAILS),
		.DATA_WIDTH (DATA_WIDTH)
	) checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.sample_value     (sample_value),
		.last_item        (last_item),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.lis_length       (lis_length),
		.overflow         (overflow),
		.fail_count       (fail_count),
		.pending          (pending),
		.samples_seen     (samples_seen),
		.results_seen     (results_seen),
		.longest_seen     (longest_seen),
		.overflow_results (overflow_results)
	);

	// one input transaction, after a random gap unless quiet
	task automatic offer(input logic [IN_W-1:0] v, input logic last);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_value <= v;
		last_item    <= last;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_sequence();
		int              kind;
		int              len;
		int              i;
		logic [IN_W-1:0] v;
		kind = $urandom_range(0, 4);
		len  = $urandom_range(1, (kind == 2) ? 40 : 20);
		v    = $urandom;
		for (i = 0; i < len; i++) begin
			case (kind)
				0: begin
					// dense small values, lots of ties
					v = $urandom_range(0, 16) - 8;
				end
				1: begin
					v = $urandom;
				end
				2: begin
					// mostly rising walk, wraps at the ends
					v = v + $urandom_range(0, 12) - 3;
				end
				3: begin
					v = v - $urandom_range(0, 5);
				end
				default: begin
					case ($urandom_range(0, 3))
						0: v = 32'h8000_0000;
						1: v = 32'h7fff_ffff;
						2: v = '0;
						default: v = $urandom;
					endcase
				end
			endcase
			offer(v, i == len - 1);
			sent_random++;
		end
	endtask

	// strictly rising run of the given number of appends, with a replacement
	// every 16 items; spill adds a replacement at the bottom and a dropped
	// append as the last item
	task automatic fill_run(input int appends, input bit spill);
		longint v;
		longint r;
		int     i;
		v = MIN_VALUE - 1;
		for (i = 0; i < appends; i++) begin
			if (i > 0 && i % 16 == 8) begin
				r = MIN_VALUE + $urandom_range(0, int'(v - MIN_VALUE));
				offer(r[IN_W-1:0], 1'b0);
			end
			v = v + $urandom_range(1, 4000);
			offer(v[IN_W-1:0], !spill && i == appends - 1);
		end
		if (spill) begin
			offer(32'h8000_0000, 1'b0);
			offer(32'h7fff_ffff, 1'b1);
		end
	endtask

	// receiver: random stalls per result, one long hold-off on request
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			stall = quiet ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int i;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single extremes
		offer(32'h8000_0000, 1'b1);
		offer(32'h7fff_ffff, 1'b1);
		// equal values replace, never append; then the extremes in both orders
		offer(32'h0, 1'b0);
		offer(32'h0, 1'b0);
		offer(32'h0, 1'b1);
		offer(32'h8000_0000, 1'b0);
		offer(32'h7fff_ffff, 1'b1);
		offer(32'h7fff_ffff, 1'b0);
		offer(32'h8000_0000, 1'b1);
		// ordering across the sign boundary
		offer(32'hffff_ffff, 1'b0);
		offer(32'h0, 1'b0);
		offer(32'h1, 1'b1);
		offer(32'h0, 1'b0);
		offer(32'hffff_ffff, 1'b1);
		offer(32'd5, 1'b0);
		offer(32'd3, 1'b0);
		offer(32'd4, 1'b0);
		offer(32'd4, 1'b0);
		offer(32'd8, 1'b1);
		offer(32'h7fff_ffff, 1'b0);
		offer(32'h4000_0000, 1'b0);
		offer(32'h8000_0001, 1'b1);
		drain();

		// receiver holds off while short sequences keep coming
		hold_req = 1'b1;
		quiet    = 1'b1;
		for (i = 0; i < 40; i++)
			offer($urandom, (i == 39) ? 1'b1 : 1'($urandom_range(0, 1)));
		while (!hold_done) @(posedge clk);
		drain();

		sent_random = 0;
		while (sent_random < RANDOM_ITEMS || results_seen < 60) begin
			// every third hundred items run without idling
			quiet = ((sent_random / 100) % 3) == 1;
			random_sequence();
		end
		drain();

		quiet = 1'b1;
		fill_run(MAX_TAILS, 1'b0);
		fill_run(MAX_TAILS + 2, 1'b1);
		// state must be clear after an overflowed sequence
		offer(32'd5, 1'b0);
		offer(32'd3, 1'b1);
		drain();
		repeat (TAIL_WAIT) @(posedge clk);

		$display("Checked %0d samples and %0d results; longest length %0d, %0d overflowed.",
			samples_seen, results_seen, longest_seen, overflow_results);
		$display("Receiver held off %0d cycles once; phases ran with and without idling.",
			HOLD_CYCLES);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#RUN_LIMIT;
		$display("FAIL");
		$finish;
	end

endmodule
